@@ hw/rtl/wavhdr_pkg.sv @@
`default_nettype none

package wavhdr_pkg;

  // Default width of the byte position counter
  localparam int POSITION_BITS = 32;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int OFFSET_W    = 31;
  localparam int SIZE_W      = 32;
  localparam int WORD_W      = 32;
  localparam int HALF_W      = 16;
  localparam int SKIP_W      = 33;
  localparam int FIELD_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_BITS    = STATUS_W + OFFSET_W + SIZE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6461_7461;

  localparam logic [WORD_W-1:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [HALF_W-1:0] PCM_CODE     = 16'd1;
  localparam logic [WORD_W-1:0] OFFSET_LIMIT = 32'h7FFF_FFFF;

  localparam logic [WORD_W-1:0] RATE_RESET     = 32'd22050;
  localparam logic [HALF_W-1:0] CHANNELS_RESET = 16'd1;
  localparam logic [HALF_W-1:0] BITS_RESET     = 16'd16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BITS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_WAVE  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FMT_SHORT = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EARLY_END = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

  // Fixed byte indexes inside header sections
  localparam logic [FIELD_W-1:0] IDX_RIFF_TAG_END = 4'd3;
  localparam logic [FIELD_W-1:0] IDX_WAVE_TAG_END = 4'd11;
  localparam logic [FIELD_W-1:0] IDX_CHUNK_TAG_W  = 4'd4;
  localparam logic [FIELD_W-1:0] IDX_CHUNK_HDR_END = 4'd7;
  localparam logic [FIELD_W-1:0] IDX_FMT_CODE     = 4'd1;
  localparam logic [FIELD_W-1:0] IDX_FMT_CHANNELS = 4'd3;
  localparam logic [FIELD_W-1:0] IDX_FMT_RATE     = 4'd7;
  localparam logic [FIELD_W-1:0] IDX_FMT_BITS     = 4'd15;

  typedef struct packed {
    logic [SIZE_W-1:0]   sample_bytes;
    logic [OFFSET_W-1:0] sample_offset;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/wav_header_chunk_parser.sv @@
`default_nettype none

// WAV header chunk parser.
// Input stream: one file byte per transfer on s_tdata. s_tuser marks the first
// byte of a new file and restarts the parse; s_tlast marks the end of the file
// and carries no byte. Before the first start mark the block parses as if a
// file began at reset.
// Output stream: at most one result per file on m_tdata: status, the offset of
// the data chunk's first byte and its size (both zero unless status is found).
// After a result every byte is dropped until the next start mark.
// Throughput: one byte per cycle while s_tready is high; all parse work for a
// byte happens in the cycle it is accepted. A result is registered into the
// result queue and shown on m_tvalid/m_tdata once older results are taken.
// A two-entry result queue sits between parser and m_* port, so input keeps
// flowing while a result waits; s_tready drops only when both entries hold
// results that the receiver has not yet taken.
// Configuration (expected rate, channels, bits) is written through cfg_we /
// cfg_index / cfg_data while the stream is idle.
// Reset (rst, synchronous) restores the register defaults 22050 Hz, 1 channel,
// 16 bits, empties the result queue and restarts the parse.

module wav_header_chunk_parser #(
  parameter int POSITION_BITS = wavhdr_pkg::POSITION_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire  [wavhdr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
  input  wire                                   s_tuser,   // [0] start_of_file
  input  wire                                   s_tlast,   // end_of_stream
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // [2:0] status, [33:3] sample_offset, [65:34] sample_bytes, [71:66] zero
  output logic [wavhdr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  wire                                   cfg_we,
  input  wire  [wavhdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [wavhdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = (POSITION_BITS > wavhdr_pkg::SKIP_W) ? POSITION_BITS
                                                            : wavhdr_pkg::SKIP_W;

  typedef enum logic [1:0] {ST_RIFF, ST_HEADER, ST_FMT, ST_SKIP} stage_t;

  // Configuration
  logic [wavhdr_pkg::WORD_W-1:0] exp_rate;
  logic [wavhdr_pkg::HALF_W-1:0] exp_channels;
  logic [wavhdr_pkg::HALF_W-1:0] exp_bits;

  // Parse state
  logic [POSITION_BITS-1:0]        byte_position, byte_position_next;
  stage_t                          stage, stage_next;
  logic [wavhdr_pkg::FIELD_W-1:0]  field_shift, field_shift_next;
  logic [wavhdr_pkg::WORD_W-1:0]   chunk_tag, chunk_tag_next;
  logic [wavhdr_pkg::WORD_W-1:0]   chunk_length, chunk_length_next;
  logic [wavhdr_pkg::SKIP_W-1:0]   skip_target, skip_target_next;
  logic                            format_good, format_good_next;
  logic                            data_seen, data_seen_next;
  logic [wavhdr_pkg::OFFSET_W-1:0] found_offset, found_offset_next;
  logic [wavhdr_pkg::SIZE_W-1:0]   found_size, found_size_next;
  logic                            finished, finished_next;

  // Result queue
  wavhdr_pkg::result_t q0, q1, res;
  logic [1:0]          q_count, q_count_after_pop;
  logic                res_valid;
  logic [wavhdr_pkg::STATUS_W-1:0] res_status;

  logic s_fire, pop, push, after_chunk;
  logic [wavhdr_pkg::FIELD_W-1:0] idx;
  logic [CW-1:0] pos_ext, skip_ext;

  assign s_fire   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign push     = res_valid;
  assign s_tready = (q_count != 2'd2);
  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = wavhdr_pkg::OUT_TDATA_W'(q0);
  assign q_count_after_pop = q_count - {1'b0, pop};

  always_comb begin
    byte_position_next = byte_position;
    stage_next         = stage;
    field_shift_next   = field_shift;
    chunk_tag_next     = chunk_tag;
    chunk_length_next  = chunk_length;
    skip_target_next   = skip_target;
    format_good_next   = format_good;
    data_seen_next     = data_seen;
    found_offset_next  = found_offset;
    found_size_next    = found_size;
    finished_next      = finished;
    res_valid          = 1'b0;
    res_status         = wavhdr_pkg::STATUS_FOUND;
    after_chunk        = 1'b0;
    idx                = field_shift;
    pos_ext            = '0;
    skip_ext           = '0;

    if (s_fire && s_tuser) begin
      byte_position_next = '0;
      stage_next         = ST_RIFF;
      field_shift_next   = '0;
      chunk_tag_next     = '0;
      chunk_length_next  = '0;
      skip_target_next   = '0;
      format_good_next   = 1'b0;
      data_seen_next     = 1'b0;
      found_offset_next  = '0;
      found_size_next    = '0;
      finished_next      = 1'b0;
      idx                = '0;
    end

    if (s_fire && !finished_next) begin
      if (s_tlast) begin
        res_valid  = 1'b1;
        res_status = wavhdr_pkg::STATUS_EARLY_END;
      end else begin
        byte_position_next = byte_position_next + POSITION_BITS'(1);
        pos_ext = CW'(byte_position_next);
        case (stage_next)
          ST_RIFF: begin
            field_shift_next = idx + wavhdr_pkg::FIELD_W'(1);
            chunk_tag_next   = {chunk_tag_next[23:0], s_tdata};
            if (idx == wavhdr_pkg::IDX_RIFF_TAG_END &&
                chunk_tag_next != wavhdr_pkg::TAG_RIFF) begin
              res_valid  = 1'b1;
              res_status = wavhdr_pkg::STATUS_NOT_WAVE;
            end else if (idx == wavhdr_pkg::IDX_WAVE_TAG_END) begin
              if (chunk_tag_next != wavhdr_pkg::TAG_WAVE) begin
                res_valid  = 1'b1;
                res_status = wavhdr_pkg::STATUS_NOT_WAVE;
              end else begin
                stage_next       = ST_HEADER;
                field_shift_next = '0;
              end
            end
          end
          ST_HEADER: begin
            field_shift_next = idx + wavhdr_pkg::FIELD_W'(1);
            if (idx < wavhdr_pkg::IDX_CHUNK_TAG_W) begin
              chunk_tag_next = {chunk_tag_next[23:0], s_tdata};
            end else begin
              chunk_length_next = {s_tdata, chunk_length_next[31:8]};
            end
            if (idx == wavhdr_pkg::IDX_CHUNK_HDR_END) begin
              if (pos_ext > CW'(wavhdr_pkg::OFFSET_LIMIT)) begin
                res_valid  = 1'b1;
                res_status = wavhdr_pkg::STATUS_OVERFLOW;
              end else begin
                // Body starts here; next header after body plus odd pad byte
                skip_target_next = {2'b00, pos_ext[wavhdr_pkg::OFFSET_W-1:0]}
                                 + {1'b0, chunk_length_next}
                                 + {32'd0, chunk_length_next[0]};
                if (chunk_tag_next == wavhdr_pkg::TAG_FMT) begin
                  if (chunk_length_next < wavhdr_pkg::FMT_MIN_LEN) begin
                    res_valid  = 1'b1;
                    res_status = wavhdr_pkg::STATUS_FMT_SHORT;
                  end else begin
                    stage_next       = ST_FMT;
                    field_shift_next = '0;
                    format_good_next = 1'b1;
                  end
                end else begin
                  if (chunk_tag_next == wavhdr_pkg::TAG_DATA) begin
                    found_offset_next = pos_ext[wavhdr_pkg::OFFSET_W-1:0];
                    found_size_next   = chunk_length_next;
                    data_seen_next    = (chunk_length_next != '0) &&
                                        !chunk_length_next[0];
                  end
                  after_chunk = 1'b1;
                end
              end
            end
          end
          ST_FMT: begin
            field_shift_next = idx + wavhdr_pkg::FIELD_W'(1);
            chunk_tag_next   = {s_tdata, chunk_tag_next[31:8]};
            case (idx)
              wavhdr_pkg::IDX_FMT_CODE:
                format_good_next = format_good_next &&
                                   chunk_tag_next[31:16] == wavhdr_pkg::PCM_CODE;
              wavhdr_pkg::IDX_FMT_CHANNELS:
                format_good_next = format_good_next &&
                                   chunk_tag_next[31:16] == exp_channels;
              wavhdr_pkg::IDX_FMT_RATE:
                format_good_next = format_good_next && chunk_tag_next == exp_rate;
              wavhdr_pkg::IDX_FMT_BITS: begin
                format_good_next = format_good_next &&
                                   chunk_tag_next[31:16] == exp_bits;
                after_chunk = 1'b1;
              end
              default: ;
            endcase
          end
          ST_SKIP: begin
            if (pos_ext >= CW'(skip_target_next)) begin
              stage_next       = ST_HEADER;
              field_shift_next = '0;
            end
          end
          default: ;
        endcase

        if (after_chunk) begin
          skip_ext = CW'(skip_target_next);
          if (format_good_next && data_seen_next) begin
            res_valid  = 1'b1;
            res_status = wavhdr_pkg::STATUS_FOUND;
          end else if (skip_ext > CW'(wavhdr_pkg::OFFSET_LIMIT)) begin
            res_valid  = 1'b1;
            res_status = wavhdr_pkg::STATUS_OVERFLOW;
          end else begin
            field_shift_next = '0;
            stage_next = (pos_ext >= skip_ext) ? ST_HEADER : ST_SKIP;
          end
        end
      end
    end

    if (res_valid) begin
      finished_next = 1'b1;
    end
    res.status        = res_status;
    res.sample_offset = (res_status == wavhdr_pkg::STATUS_FOUND) ? found_offset_next : '0;
    res.sample_bytes  = (res_status == wavhdr_pkg::STATUS_FOUND) ? found_size_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_rate      <= wavhdr_pkg::RATE_RESET;
      exp_channels  <= wavhdr_pkg::CHANNELS_RESET;
      exp_bits      <= wavhdr_pkg::BITS_RESET;
      byte_position <= '0;
      stage         <= ST_RIFF;
      field_shift   <= '0;
      chunk_tag     <= '0;
      chunk_length  <= '0;
      skip_target   <= '0;
      format_good   <= 1'b0;
      data_seen     <= 1'b0;
      found_offset  <= '0;
      found_size    <= '0;
      finished      <= 1'b0;
      q_count       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wavhdr_pkg::REG_SAMPLE_RATE: exp_rate     <= cfg_data;
          wavhdr_pkg::REG_CHANNELS:    exp_channels <= cfg_data[wavhdr_pkg::HALF_W-1:0];
          wavhdr_pkg::REG_SAMPLE_BITS: exp_bits     <= cfg_data[wavhdr_pkg::HALF_W-1:0];
          default: ;
        endcase
      end
      byte_position <= byte_position_next;
      stage         <= stage_next;
      field_shift   <= field_shift_next;
      chunk_tag     <= chunk_tag_next;
      chunk_length  <= chunk_length_next;
      skip_target   <= skip_target_next;
      format_good   <= format_good_next;
      data_seen     <= data_seen_next;
      found_offset  <= found_offset_next;
      found_size    <= found_size_next;
      finished      <= finished_next;
      q_count       <= q_count_after_pop + {1'b0, push};
    end
  end

  // Queue payload: shift on pop, write the new result into the first free slot
  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= q1;
    end
    if (push) begin
      if (q_count_after_pop == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Only one result per file: none while finished unless a start mark arrives
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (finished && !(s_fire && s_tuser)) |-> !push)
    else $error("result produced after the file already reported");

  // A found result needs both a good format and a valid data chunk
  a_found_needs_both: assert property (@(posedge clk) disable iff (rst)
    (push && res.status == wavhdr_pkg::STATUS_FOUND) |-> (format_good_next && data_seen_next))
    else $error("found reported without good format and data chunk");

  // Error results carry no offset or size
  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (push && res.status != wavhdr_pkg::STATUS_FOUND) |->
      (res.sample_offset == '0 && res.sample_bytes == '0))
    else $error("error result with nonzero payload");

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_count == 2'd2 && !pop) |=> (q_count == 2'd2))
    else $error("result queue lost or gained an entry while full");

  // Reset leaves the parser at the top of a file with nothing pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> (stage == ST_RIFF && !finished && q_count == 2'd0))
    else $error("parser not restarted by reset");
`endif

endmodule

`default_nettype wire

@@ dv/wav_header_chunk_parser_tb.sv @@
module wav_header_chunk_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {STG_RIFF, STG_HEADER, STG_FMT, STG_SKIP} stage_t;

  typedef struct packed {
    logic [wavhdr_pkg::BYTE_W-1:0] data;
    logic                          sof;
    logic                          eos;
  } file_item_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [wavhdr_pkg::BYTE_W-1:0]      s_tdata = '0;   // [7:0] data_byte
  logic                               s_tuser = 1'b0; // [0] start_of_file
  logic                               s_tlast = 1'b0; // end_of_stream
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  // [2:0] status, [33:3] sample_offset, [65:34] sample_bytes, [71:66] zero
  logic [wavhdr_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                               cfg_we = 1'b0;
  logic [wavhdr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wavhdr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // parser mirror: configuration and parse state
  logic [wavhdr_pkg::WORD_W-1:0]   exp_rate;
  logic [wavhdr_pkg::HALF_W-1:0]   exp_chan;
  logic [wavhdr_pkg::HALF_W-1:0]   exp_bits;
  logic [wavhdr_pkg::WORD_W-1:0]   pos_cnt;
  stage_t                          stage;
  int unsigned                     sec_idx;
  logic [wavhdr_pkg::WORD_W-1:0]   tag_sr;
  logic [wavhdr_pkg::WORD_W-1:0]   chunk_len;
  logic [wavhdr_pkg::SKIP_W-1:0]   next_hdr;
  bit                              fmt_ok;
  bit                              data_ok;
  logic [wavhdr_pkg::OFFSET_W-1:0] data_off;
  logic [wavhdr_pkg::SIZE_W-1:0]   data_len;
  bit                              reported;

  wavhdr_pkg::result_t pending_reports[$];
  file_item_t          byte_stream_q[$];
  logic [7:0]          file_bytes[$];
  int unsigned         mismatch_cnt = 0;

  // format that generated fmt chunks state
  logic [wavhdr_pkg::WORD_W-1:0] gen_rate = wavhdr_pkg::RATE_RESET;
  logic [wavhdr_pkg::HALF_W-1:0] gen_chan = wavhdr_pkg::CHANNELS_RESET;
  logic [wavhdr_pkg::HALF_W-1:0] gen_bits = wavhdr_pkg::BITS_RESET;

  bit          s_fire = 1'b0;
  file_item_t  tx_item;
  int unsigned tx_wait = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_calm = 0;
  int unsigned hold_left = 0;
  bit          burst_req = 1'b0;
  bit          burst_started = 1'b0;

  wav_header_chunk_parser dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void restart_parse();
    pos_cnt = '0;
    stage = STG_RIFF;
    sec_idx = 0;
    tag_sr = '0;
    chunk_len = '0;
    next_hdr = '0;
    fmt_ok = 1'b0;
    data_ok = 1'b0;
    data_off = '0;
    data_len = '0;
    reported = 1'b0;
  endfunction

  function automatic bit finish_file(input logic [wavhdr_pkg::STATUS_W-1:0] st,
                                     output wavhdr_pkg::result_t r);
    reported = 1'b1;
    r.status = st;
    r.sample_offset = (st == wavhdr_pkg::STATUS_FOUND) ? data_off : '0;
    r.sample_bytes = (st == wavhdr_pkg::STATUS_FOUND) ? data_len : '0;
    return 1'b1;
  endfunction

  function automatic bit close_chunk(output wavhdr_pkg::result_t r);
    if (fmt_ok && data_ok) return finish_file(wavhdr_pkg::STATUS_FOUND, r);
    if (next_hdr > {1'b0, wavhdr_pkg::OFFSET_LIMIT})
      return finish_file(wavhdr_pkg::STATUS_OVERFLOW, r);
    sec_idx = 0;
    stage = ({1'b0, pos_cnt} >= next_hdr) ? STG_HEADER : STG_SKIP;
    return 1'b0;
  endfunction

  // Advance the mirror by one transfer; return 1 when the file gets its report.
  function automatic bit parse_wav_byte(input logic [7:0] b, input bit sof, input bit eos,
                                        output wavhdr_pkg::result_t r);
    int unsigned i;
    r = '0;
    if (sof) restart_parse();
    if (reported) return 1'b0;
    if (eos) return finish_file(wavhdr_pkg::STATUS_EARLY_END, r);
    pos_cnt = pos_cnt + 1'b1;
    i = sec_idx;
    case (stage)
      STG_RIFF: begin
        sec_idx = i + 1;
        tag_sr = {tag_sr[23:0], b};
        if (i == 3 && tag_sr != wavhdr_pkg::TAG_RIFF)
          return finish_file(wavhdr_pkg::STATUS_NOT_WAVE, r);
        if (i == 11) begin
          if (tag_sr != wavhdr_pkg::TAG_WAVE)
            return finish_file(wavhdr_pkg::STATUS_NOT_WAVE, r);
          stage = STG_HEADER;
          sec_idx = 0;
        end
      end
      STG_HEADER: begin
        sec_idx = i + 1;
        if (i < 4) tag_sr = {tag_sr[23:0], b};
        else chunk_len = {b, chunk_len[31:8]};
        if (i == 7) begin
          if (pos_cnt > wavhdr_pkg::OFFSET_LIMIT)
            return finish_file(wavhdr_pkg::STATUS_OVERFLOW, r);
          next_hdr = {1'b0, pos_cnt} + {1'b0, chunk_len}
                   + wavhdr_pkg::SKIP_W'(chunk_len[0]);
          if (tag_sr == wavhdr_pkg::TAG_FMT) begin
            if (chunk_len < wavhdr_pkg::FMT_MIN_LEN)
              return finish_file(wavhdr_pkg::STATUS_FMT_SHORT, r);
            stage = STG_FMT;
            sec_idx = 0;
            fmt_ok = 1'b1;
            return 1'b0;
          end
          if (tag_sr == wavhdr_pkg::TAG_DATA) begin
            data_off = pos_cnt[wavhdr_pkg::OFFSET_W-1:0];
            data_len = chunk_len;
            data_ok = chunk_len != 0 && !chunk_len[0];
          end
          return close_chunk(r);
        end
      end
      STG_FMT: begin
        sec_idx = i + 1;
        tag_sr = {b, tag_sr[31:8]};
        if (i == 1) fmt_ok = fmt_ok && tag_sr[31:16] == wavhdr_pkg::PCM_CODE;
        else if (i == 3) fmt_ok = fmt_ok && tag_sr[31:16] == exp_chan;
        else if (i == 7) fmt_ok = fmt_ok && tag_sr == exp_rate;
        else if (i == 15) begin
          fmt_ok = fmt_ok && tag_sr[31:16] == exp_bits;
          return close_chunk(r);
        end
      end
      STG_SKIP: begin
        if ({1'b0, pos_cnt} >= next_hdr) begin
          stage = STG_HEADER;
          sec_idx = 0;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (r < 130) return 0;
    if (r < 185) return $urandom_range(1, 3);
    if (r < 198) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_result(input string what, input wavhdr_pkg::result_t want,
                             input wavhdr_pkg::result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected %0d/%0d/%0d got %0d/%0d/%0d (status/offset/size)",
               $time, what, want.status, want.sample_offset, want.sample_bytes,
               got.status, got.sample_offset, got.sample_bytes);
  endtask

  // Sender: hold an offered byte until its transfer, then pause at random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (byte_stream_q.size() != 0) begin
        tx_item = byte_stream_q.pop_front();
        s_tdata <= tx_item.data;
        s_tuser <= tx_item.sof;
        s_tlast <= tx_item.eos;
        s_tvalid <= 1'b1;
        tx_wait = pick_gap(tx_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the result queue.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (burst_req && !burst_started) begin
        burst_started = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_wait = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    wavhdr_pkg::result_t got;
    wavhdr_pkg::result_t want;
    wavhdr_pkg::result_t fresh;
    if (rst) begin
      s_fire <= 1'b0;
      exp_rate = wavhdr_pkg::RATE_RESET;
      exp_chan = wavhdr_pkg::CHANNELS_RESET;
      exp_bits = wavhdr_pkg::BITS_RESET;
      restart_parse();
      pending_reports.delete();
    end else begin
      s_fire <= s_tvalid && s_tready;
      if (cfg_we) begin
        case (cfg_index)
          wavhdr_pkg::REG_SAMPLE_RATE: exp_rate = cfg_data;
          wavhdr_pkg::REG_CHANNELS:    exp_chan = cfg_data[wavhdr_pkg::HALF_W-1:0];
          wavhdr_pkg::REG_SAMPLE_BITS: exp_bits = cfg_data[wavhdr_pkg::HALF_W-1:0];
          default: ;
        endcase
      end
      // check outgoing reports before predicting: a report trails its byte
      if (m_tvalid && m_tready) begin
        got = wavhdr_pkg::result_t'(m_tdata[wavhdr_pkg::OUT_BITS-1:0]);
        if (pending_reports.size() == 0) begin
          flag_result("report with none pending", '0, got);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) flag_result("report mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready && parse_wav_byte(s_tdata, s_tuser, s_tlast, fresh))
        pending_reports.push_back(fresh);
    end
  end

  function automatic void put_be32(input logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_le16(input logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endfunction

  function automatic void put_le32(input logic [31:0] w);
    put_le16(w[15:0]);
    put_le16(w[31:16]);
  endfunction

  function automatic void put_body(input int unsigned n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_junk();
    int unsigned n;
    n = $urandom_range(0, 9);
    put_be32($urandom);
    put_le32(n);
    put_body(n + n % 2);
  endfunction

  function automatic void put_data(input logic [31:0] len, input bit with_body);
    put_be32(wavhdr_pkg::TAG_DATA);
    put_le32(len);
    if (with_body) put_body(len + len[0]);
  endfunction

  // fmt header and the 16 format bytes; fault picks one field to spoil
  function automatic void put_fmt(input logic [31:0] len, input int unsigned fault);
    put_be32(wavhdr_pkg::TAG_FMT);
    put_le32(len);
    put_le16(fault == 1 ? wavhdr_pkg::PCM_CODE ^ (16'd1 << $urandom_range(0, 15))
                        : wavhdr_pkg::PCM_CODE);
    put_le16(fault == 2 ? gen_chan ^ (16'd1 << $urandom_range(0, 15)) : gen_chan);
    put_le32(fault == 3 ? gen_rate ^ (32'd1 << $urandom_range(0, 31)) : gen_rate);
    put_le32($urandom);
    put_le16(16'($urandom));
    put_le16(fault == 4 ? gen_bits ^ (16'd1 << $urandom_range(0, 15)) : gen_bits);
  endfunction

  function automatic void send_file(input bit sof, input int unsigned len, input bit eos);
    for (int unsigned i = 0; i < len; i++)
      byte_stream_q.push_back('{file_bytes[i], sof && i == 0, 1'b0});
    if (eos) byte_stream_q.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  function automatic void add_random_file();
    int unsigned r;
    int unsigned k;
    int unsigned fault;
    int unsigned fmt_len;
    int unsigned cut;
    logic [31:0] dlen;
    bit data_first;
    bit big;
    r = $urandom_range(0, 99);
    file_bytes.delete();
    if (r >= 96) begin
      // start and end on one transfer
      byte_stream_q.push_back('{8'($urandom), 1'b1, 1'b1});
      return;
    end
    if (r >= 90) begin
      put_body($urandom_range(1, 16));
      send_file(r < 94, file_bytes.size(), $urandom_range(0, 1));
      return;
    end
    if (r >= 82) begin
      // spoil one tag byte of the RIFF/WAVE header
      put_be32(wavhdr_pkg::TAG_RIFF);
      put_le32($urandom);
      put_be32(wavhdr_pkg::TAG_WAVE);
      put_body($urandom_range(0, 6));
      k = $urandom_range(0, 7);
      if (k >= 4) k += 4;
      file_bytes[k] ^= 8'($urandom_range(1, 255));
      send_file(1'b1, file_bytes.size(), $urandom_range(0, 1));
      return;
    end
    put_be32(wavhdr_pkg::TAG_RIFF);
    put_le32($urandom);
    put_be32(wavhdr_pkg::TAG_WAVE);
    repeat ($urandom_range(0, 2)) put_junk();
    if (r < 8) begin
      put_be32(wavhdr_pkg::TAG_FMT);
      put_le32($urandom_range(0, 15));
    end else if (r < 16) begin
      // chunk whose end lies past the offset limit
      case ($urandom_range(0, 2))
        0: put_be32(wavhdr_pkg::TAG_FMT);
        1: put_be32(wavhdr_pkg::TAG_DATA);
        default: put_be32($urandom);
      endcase
      put_le32($urandom_range(32'h7FFF_FFC0, 32'hFFFF_FFFF));
      put_body(16);
    end else begin
      fault = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
      data_first = $urandom_range(0, 3) == 0;
      big = !data_first && fault == 0 && $urandom_range(0, 4) == 0;
      if ($urandom_range(0, 5) == 0) dlen = $urandom_range(0, 7);
      else if (big) dlen = $urandom & ~32'd1;
      else dlen = 2 * $urandom_range(1, 6);
      fmt_len = 16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
      if (data_first) put_data(dlen, 1'b1);
      put_fmt(fmt_len, fault);
      put_body(fmt_len - 16 + fmt_len % 2);
      // a large data chunk reports at its header, so drop the body
      if (!data_first) put_data(dlen, !big);
      if ($urandom_range(0, 3) == 0) put_junk();
    end
    cut = (r >= 16 && r < 30) ? $urandom_range(1, file_bytes.size() - 1) : file_bytes.size();
    send_file($urandom_range(0, 24) != 0, cut, $urandom_range(0, 9) != 0);
  endfunction

  function automatic void fill_files(input int unsigned n);
    int unsigned goal;
    goal = byte_stream_q.size() + n;
    while (byte_stream_q.size() < goal) add_random_file();
  endfunction

  task automatic wait_idle();
    while (byte_stream_q.size() != 0 || s_tvalid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wavhdr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wavhdr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_format(input logic [31:0] rate, input logic [15:0] chan,
                            input logic [15:0] bits);
    wait_idle();
    write_reg(wavhdr_pkg::REG_SAMPLE_RATE, rate);
    write_reg(wavhdr_pkg::REG_CHANNELS, 32'(chan));
    write_reg(wavhdr_pkg::REG_SAMPLE_BITS, 32'(bits));
    gen_rate = rate;
    gen_chan = chan;
    gen_bits = bits;
  endtask

  initial begin
    // bad RIFF tag on the first file after reset, no start mark
    put_be32(wavhdr_pkg::TAG_RIFF ^ 32'h46);
    send_file(1'b0, 4, 1'b0);
    // bad WAVE tag, all-ones size
    file_bytes.delete();
    put_be32(wavhdr_pkg::TAG_RIFF);
    put_le32('1);
    put_be32(wavhdr_pkg::TAG_WAVE ^ 32'h1);
    send_file(1'b1, 12, 1'b0);
    byte_stream_q.push_back('{8'hFF, 1'b1, 1'b1});
    // end inside the RIFF/WAVE header, then an end mark that gets dropped
    file_bytes.delete();
    put_be32(wavhdr_pkg::TAG_RIFF);
    send_file(1'b1, 4, 1'b1);
    byte_stream_q.push_back('{8'h00, 1'b0, 1'b1});

    fill_files(300);
    set_format('1, '1, '1);
    fill_files(300);
    set_format('0, '0, '0);
    fill_files(300);

    wait_idle();
    burst_req = 1'b1;
    repeat (30) begin
      file_bytes.delete();
      put_be32(wavhdr_pkg::TAG_RIFF ^ 32'h1);
      send_file(1'b1, 4, 1'b0);
    end

    set_format($urandom, 16'($urandom_range(1, 8)), 16'(8 * $urandom_range(1, 4)));
    fill_files(300);
    set_format(32'd44100, 16'd2, 16'd16);
    fill_files(300);

    while (byte_stream_q.size() != 0 || s_tvalid) @(posedge clk);
    for (int n = 0; n < 2000 && pending_reports.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
